FILE: src/spke_pkg.sv
// Shared types and constants for the SPH smoothing kernel evaluator.
`timescale 1ns / 1ps
`default_nettype none

package spke_pkg;

    // Width of one quotient produced by the spiky divider (one bit per stage)
    localparam int DIV_BITS = 33;

    // Clamp limits of the signed Q16.16 result, as 33 bit magnitudes
    localparam logic [32:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [32:0] LIM_NEG = 33'h0_8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Register values after reset
    localparam logic [30:0] RST_RADIUS    = 31'd65536;
    localparam logic [30:0] RST_RADIUS_SQ = 31'd65536;
    localparam logic [46:0] RST_POLY6     = 47'd102674;
    localparam logic [47:0] RST_SPIKY     = 48'(-938733);
    localparam logic [46:0] RST_VISC      = 47'd938733;

    // Kernel select codes
    typedef enum logic [1:0] {
        CMD_POLY6 = 2'd0,
        CMD_SPIKY = 2'd1,
        CMD_VISC  = 2'd2
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RADIUS    = 3'd0,
        REG_RADIUS_SQ = 3'd1,
        REG_POLY6     = 3'd2,
        REG_SPIKY     = 3'd3,
        REG_VISC      = 3'd4
    } reg_idx_t;

    // One divider lane: partial remainder, dividend bits still to shift in,
    // quotient so far, result sign and early overflow
    typedef struct packed {
        logic [30:0] rem;
        logic [32:0] bits;
        logic [32:0] quo;
        logic        neg;
        logic        over;
    } div_lane_t;

    // Sideband that travels with the divider lanes
    typedef struct packed {
        logic        spiky;
        logic [31:0] scalar;
        logic        scalar_sat;
        logic [30:0] divisor;
    } div_side_t;

endpackage

`default_nettype wire

FILE: src/spke_if.sv
// Request and result channel interfaces of the SPH kernel evaluator.
`timescale 1ns / 1ps
`default_nettype none

interface spke_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [31:0] distance_value;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;

    modport source (
        output valid, command, distance_value, disp_x, disp_y, disp_z,
        input  ready
    );
    modport sink (
        input  valid, command, distance_value, disp_x, disp_y, disp_z,
        output ready
    );
endinterface

interface spke_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic               saturated;

    modport source (
        output valid, value_x, value_y, value_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, value_x, value_y, value_z, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/sph_smoothing_kernel_eval.sv
// Top level of the SPH smoothing kernel evaluator (poly6, spiky, viscosity).
//
//  Channel  Kind          Carries
//  req      valid/ready   command, distance_value, disp_x, disp_y, disp_z
//  rsp      valid/ready   value_x, value_y, value_z, saturated
//  cfg      write only    cfg_write, cfg_index, cfg_data
//
// One request enters per cycle while the skid buffer is empty; its result passes
// the eight stages of input, support test and multiplies, then the 33-stage
// divider of the spiky gradient, then the result register.
// Every stage advances together while the result register is empty or taken.
// A one-entry skid buffer takes a request during a stall, so req.ready
// comes from a register. Reset empties the pipeline and loads the registers.
`timescale 1ns / 1ps
`default_nettype none

module sph_smoothing_kernel_eval (
    input  wire logic        clk,
    input  wire logic        rst_n,
    spke_req_if.sink         req,
    spke_rsp_if.source       rsp,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import spke_pkg::*;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [31:0]      dval;
        logic [2:0][31:0] disp;
    } req_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic             live;
        logic [30:0]      d;
        logic [30:0]      r;
        logic [2:0][31:0] dmag;
        logic [2:0]       dneg;
    } ctx_t;

    // Four partial products of a 48 x 46 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [45:0] lh;
        logic [47:0] hl;
        logic [29:0] hh;
    } pp1_t;

    // Four partial products of a 47 x 47 multiply
    typedef struct packed {
        logic [63:0] ll;
        logic [46:0] lh;
        logic [46:0] hl;
        logic [29:0] hh;
    } pp2_t;

    // Configuration registers
    logic [30:0] radius_reg;
    logic [30:0] radius_sq_reg;
    logic [46:0] poly6_reg;
    logic [47:0] spiky_reg;
    logic [46:0] visc_reg;

    // Pipeline registers
    logic             adv;
    logic             take_in;
    req_t             in_req;
    logic             skid_valid_reg;
    req_t             skid_reg;
    logic             s1_valid_reg;
    req_t             s1_reg;
    logic             s2_valid_reg;
    ctx_t             s2_ctx_reg;
    ctx_t             s2_next;
    logic             s3_valid_reg;
    ctx_t             s3_ctx_reg;
    logic [61:0]      s3_sq_reg;
    logic             s4_valid_reg;
    ctx_t             s4_ctx_reg;
    pp1_t             s4_pp_reg;
    pp1_t             s4_next;
    logic             s5_valid_reg;
    ctx_t             s5_ctx_reg;
    logic [93:0]      s5_prod_reg;
    logic             s6_valid_reg;
    ctx_t             s6_ctx_reg;
    pp2_t             s6_pp_reg;
    pp2_t             s6_pp_next;
    logic             s6_big_reg;
    logic [2:0][63:0] s6_ll_reg;
    logic [2:0][62:0] s6_lh_reg;
    logic [2:0][63:0] s6_ll_next;
    logic [2:0][62:0] s6_lh_next;
    logic [31:0]      s6_visc_reg;
    logic             s6_visc_sat_reg;
    logic             s7_valid_reg;
    ctx_t             s7_ctx_reg;
    logic [2:0][94:0] s7_p_reg;
    logic [2:0][94:0] s7_p_next;
    logic [31:0]      s7_scalar_reg;
    logic             s7_sat_reg;
    logic [31:0]      s7_scalar_next;
    logic             s7_sat_next;
    logic             s8_valid_reg;
    div_side_t        s8_side_reg;
    div_lane_t [2:0]  s8_lane_reg;
    div_side_t        s8_side_next;
    div_lane_t [2:0]  s8_lane_next;
    logic             dv_valid;
    div_side_t        dv_side;
    div_lane_t [2:0]  dv_lane;
    logic             o_valid_reg;
    logic [2:0][31:0] o_val_reg;
    logic             o_sat_reg;
    logic             o_spiky_reg;
    logic [2:0][31:0] o_val_next;
    logic             o_sat_next;

    // Magnitude and sign of the spiky coefficient
    logic [47:0] cmag;
    logic        cneg;
    assign cneg = spiky_reg[47];
    assign cmag = cneg ? (~spiky_reg + 48'd1) : spiky_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RST_RADIUS;
            radius_sq_reg <= RST_RADIUS_SQ;
            poly6_reg     <= RST_POLY6;
            spiky_reg     <= RST_SPIKY;
            visc_reg      <= RST_VISC;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_RADIUS:    radius_reg    <= cfg_data[30:0];
                REG_RADIUS_SQ: radius_sq_reg <= cfg_data[30:0];
                REG_POLY6:     poly6_reg     <= cfg_data[46:0];
                REG_SPIKY:     spiky_reg     <= cfg_data;
                REG_VISC:      visc_reg      <= cfg_data[46:0];
                default:       ;
            endcase
        end
    end

    // Handshake: advance while the result register is free or being taken
    assign adv       = !o_valid_reg || rsp.ready;
    assign req.ready = !skid_valid_reg;
    assign take_in   = req.valid && !skid_valid_reg;

    assign in_req.cmd     = req.command;
    assign in_req.dval    = req.distance_value;
    assign in_req.disp[0] = req.disp_x;
    assign in_req.disp[1] = req.disp_y;
    assign in_req.disp[2] = req.disp_z;

    // Stage 2: support test, distance to the edge, displacement magnitudes
    always_comb
    begin
        s2_next     = '0;
        s2_next.cmd = s1_reg.cmd;
        s2_next.r   = s1_reg.dval[30:0];
        for (int j = 0; j < 3; j++)
        begin
            s2_next.dneg[j] = s1_reg.disp[j][31];
            s2_next.dmag[j] = s1_reg.disp[j][31] ? (~s1_reg.disp[j] + 32'd1)
                                                  : s1_reg.disp[j];
        end
        case (s1_reg.cmd)
            CMD_POLY6:
            begin
                s2_next.live = !s1_reg.dval[31] && (s1_reg.dval[30:0] < radius_sq_reg);
                s2_next.d    = radius_sq_reg - s1_reg.dval[30:0];
            end
            CMD_SPIKY:
            begin
                s2_next.live = !s1_reg.dval[31] && (s1_reg.dval[30:0] != 31'd0)
                               && (s1_reg.dval[30:0] < radius_reg);
                s2_next.d    = radius_reg - s1_reg.dval[30:0];
            end
            CMD_VISC:
            begin
                s2_next.live = !s1_reg.dval[31] && (s1_reg.dval[30:0] < radius_reg);
                s2_next.d    = radius_reg - s1_reg.dval[30:0];
            end
            default:
            begin
                s2_next.live = 1'b0;
                s2_next.d    = '0;
            end
        endcase
    end

    // Stage 4: shared multiplier, split into four partial products
    always_comb
    begin
        logic [47:0] a;
        logic [45:0] b;
        case (s3_ctx_reg.cmd)
            CMD_POLY6:
            begin
                a = {17'd0, s3_ctx_reg.d};
                b = s3_sq_reg[61:16];
            end
            CMD_SPIKY:
            begin
                a = cmag;
                b = s3_sq_reg[61:16];
            end
            CMD_VISC:
            begin
                a = {1'b0, visc_reg};
                b = {15'd0, s3_ctx_reg.d};
            end
            default:
            begin
                a = '0;
                b = '0;
            end
        endcase
        s4_next.ll = a[31:0] * b[31:0];
        s4_next.lh = a[31:0] * b[45:32];
        s4_next.hl = a[47:32] * b[31:0];
        s4_next.hh = a[47:32] * b[45:32];
    end

    // Stage 6: poly6 coefficient partials and spiky gradient partials
    always_comb
    begin
        logic [77:0] sh;
        logic [62:0] m;
        logic [46:0] t3;
        sh = s5_prod_reg[93:16];
        t3 = sh[46:0];
        s6_pp_next.ll = poly6_reg[31:0] * t3[31:0];
        s6_pp_next.lh = poly6_reg[31:0] * t3[46:32];
        s6_pp_next.hl = poly6_reg[46:32] * t3[31:0];
        s6_pp_next.hh = poly6_reg[46:32] * t3[46:32];
        // cap the gradient scale at 2^62
        if ((|sh[77:63]) || (sh[62] && (|sh[61:0])))
        begin
            m = 63'h4000_0000_0000_0000;
        end
        else
        begin
            m = sh[62:0];
        end
        for (int j = 0; j < 3; j++)
        begin
            s6_ll_next[j] = m[31:0] * s5_ctx_reg.dmag[j];
            s6_lh_next[j] = m[62:32] * s5_ctx_reg.dmag[j];
        end
    end

    // Stage 7: finish poly6, pick the scalar, sum the gradient partials
    always_comb
    begin
        logic [93:0] p2;
        logic        poly_sat;
        p2 = 94'(s6_pp_reg.ll) + (94'(s6_pp_reg.lh) << 32)
           + (94'(s6_pp_reg.hl) << 32) + (94'(s6_pp_reg.hh) << 64);
        poly_sat = s6_big_reg || (|p2[93:47]);
        s7_scalar_next = '0;
        s7_sat_next    = 1'b0;
        if (s6_ctx_reg.live)
        begin
            case (s6_ctx_reg.cmd)
                CMD_POLY6:
                begin
                    s7_scalar_next = poly_sat ? POS_MAX : {1'b0, p2[46:16]};
                    s7_sat_next    = poly_sat;
                end
                CMD_VISC:
                begin
                    s7_scalar_next = s6_visc_reg;
                    s7_sat_next    = s6_visc_sat_reg;
                end
                default:
                begin
                    s7_scalar_next = '0;
                    s7_sat_next    = 1'b0;
                end
            endcase
        end
        for (int j = 0; j < 3; j++)
        begin
            s7_p_next[j] = 95'(s6_ll_reg[j]) + (95'(s6_lh_reg[j]) << 32);
        end
    end

    // Stage 8: load the divider lanes, flag quotients past 33 bits
    always_comb
    begin
        s8_side_next.spiky      = s7_ctx_reg.live && (s7_ctx_reg.cmd == CMD_SPIKY);
        s8_side_next.scalar     = s7_scalar_reg;
        s8_side_next.scalar_sat = s7_sat_reg;
        s8_side_next.divisor    = s7_ctx_reg.r;
        for (int j = 0; j < 3; j++)
        begin
            s8_lane_next[j].over = s7_p_reg[j][94:33] >= {31'd0, s7_ctx_reg.r};
            s8_lane_next[j].rem  = s7_p_reg[j][63:33];
            s8_lane_next[j].bits = s7_p_reg[j][32:0];
            s8_lane_next[j].quo  = '0;
            s8_lane_next[j].neg  = cneg ^ s7_ctx_reg.dneg[j];
        end
    end

    spke_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s8_valid_reg),
        .in_side   (s8_side_reg),
        .in_lane   (s8_lane_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_lane  (dv_lane)
    );

    // Output stage: clamp, apply signs, merge with the scalar kernels
    always_comb
    begin
        logic [32:0] limit [3];
        logic        sat   [3];
        logic [31:0] mag   [3];
        for (int j = 0; j < 3; j++)
        begin
            limit[j] = dv_lane[j].neg ? LIM_NEG : LIM_POS;
            sat[j]   = dv_lane[j].over || (dv_lane[j].quo > limit[j]);
            mag[j]   = sat[j] ? limit[j][31:0] : dv_lane[j].quo[31:0];
        end
        if (dv_side.spiky)
        begin
            for (int j = 0; j < 3; j++)
            begin
                o_val_next[j] = dv_lane[j].neg ? (~mag[j] + 32'd1) : mag[j];
            end
            o_sat_next = sat[0] || sat[1] || sat[2];
        end
        else
        begin
            o_val_next[0] = dv_side.scalar;
            o_val_next[1] = '0;
            o_val_next[2] = '0;
            o_sat_next    = dv_side.scalar_sat;
        end
    end

    // Advance valid bits and the skid buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            s7_valid_reg   <= 1'b0;
            s8_valid_reg   <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else if (adv)
        begin
            skid_valid_reg <= 1'b0;
            s1_valid_reg   <= skid_valid_reg || take_in;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            s5_valid_reg   <= s4_valid_reg;
            s6_valid_reg   <= s5_valid_reg;
            s7_valid_reg   <= s6_valid_reg;
            s8_valid_reg   <= s7_valid_reg;
            o_valid_reg    <= dv_valid;
        end
        else if (take_in)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Hold a request that arrives during a stall
    always_ff @(posedge clk)
    begin
        if (!adv && take_in)
        begin
            skid_reg <= in_req;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg          <= skid_valid_reg ? skid_reg : in_req;
            s2_ctx_reg      <= s2_next;
            s3_ctx_reg      <= s2_ctx_reg;
            s3_sq_reg       <= s2_ctx_reg.d * s2_ctx_reg.d;
            s4_ctx_reg      <= s3_ctx_reg;
            s4_pp_reg       <= s4_next;
            s5_ctx_reg      <= s4_ctx_reg;
            s5_prod_reg     <= 94'(s4_pp_reg.ll) + (94'(s4_pp_reg.lh) << 32)
                             + (94'(s4_pp_reg.hl) << 32) + (94'(s4_pp_reg.hh) << 64);
            s6_ctx_reg      <= s5_ctx_reg;
            s6_pp_reg       <= s6_pp_next;
            s6_big_reg      <= (|s5_prod_reg[93:63]) && (|poly6_reg);
            s6_ll_reg       <= s6_ll_next;
            s6_lh_reg       <= s6_lh_next;
            s6_visc_sat_reg <= |s5_prod_reg[93:47];
            s6_visc_reg     <= (|s5_prod_reg[93:47]) ? POS_MAX
                                                     : {1'b0, s5_prod_reg[46:16]};
            s7_ctx_reg      <= s6_ctx_reg;
            s7_p_reg        <= s7_p_next;
            s7_scalar_reg   <= s7_scalar_next;
            s7_sat_reg      <= s7_sat_next;
            s8_side_reg     <= s8_side_next;
            s8_lane_reg     <= s8_lane_next;
            o_val_reg       <= o_val_next;
            o_sat_reg       <= o_sat_next;
            o_spiky_reg     <= dv_side.spiky;
        end
    end

    assign rsp.valid     = o_valid_reg;
    assign rsp.value_x   = o_val_reg[0];
    assign rsp.value_y   = o_val_reg[1];
    assign rsp.value_z   = o_val_reg[2];
    assign rsp.saturated = o_sat_reg;

    // Scalar kernels leave the y and z components at zero
    a_scalar_yz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !o_spiky_reg |-> rsp.value_y == '0 && rsp.value_z == '0)
        else $error("scalar kernel result has nonzero y or z");

    // A clamped scalar kernel shows the positive limit
    a_scalar_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.saturated && !o_spiky_reg |-> rsp.value_x == POS_MAX)
        else $error("clamped scalar result is not the positive limit");

    // The skid buffer fills only while the pipeline is stalled
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> !$past(adv))
        else $error("skid buffer filled while the pipeline advanced");

endmodule

`default_nettype wire

FILE: src/spke_div_pipe.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module spke_div_pipe (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire spke_pkg::div_side_t         in_side,
    input  wire spke_pkg::div_lane_t [2:0]   in_lane,
    output logic                             out_valid,
    output spke_pkg::div_side_t              out_side,
    output spke_pkg::div_lane_t [2:0]        out_lane
);
    import spke_pkg::*;

    logic                valid_reg [DIV_BITS];
    div_side_t           side_reg  [DIV_BITS];
    div_lane_t [2:0]     lane_reg  [DIV_BITS];

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic            v_prev;
        div_side_t       s_prev;
        div_lane_t [2:0] l_prev;
        div_lane_t [2:0] lane_next;

        // Pick the stage feeding this one
        if (k == 0)
        begin : g_first
            assign v_prev = in_valid;
            assign s_prev = in_side;
            assign l_prev = in_lane;
        end
        else
        begin : g_rest
            assign v_prev = valid_reg[k-1];
            assign s_prev = side_reg[k-1];
            assign l_prev = lane_reg[k-1];
        end

        // Shift in one dividend bit, subtract the divisor where it fits
        always_comb
        begin
            logic [31:0] trial [3];
            logic [32:0] diff  [3];
            lane_next = l_prev;
            for (int j = 0; j < 3; j++)
            begin
                trial[j] = {l_prev[j].rem, l_prev[j].bits[32]};
                diff[j]  = {1'b0, trial[j]} - {2'b00, s_prev.divisor};
                lane_next[j].bits = {l_prev[j].bits[31:0], 1'b0};
                if (!diff[j][32])
                begin
                    lane_next[j].rem = diff[j][30:0];
                    lane_next[j].quo = {l_prev[j].quo[31:0], 1'b1};
                end
                else
                begin
                    lane_next[j].rem = trial[j][30:0];
                    lane_next[j].quo = {l_prev[j].quo[31:0], 1'b0};
                end
            end
        end

        // Advance valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= v_prev;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[k] <= s_prev;
                lane_reg[k] <= lane_next;
            end
        end
    end

    assign out_valid = valid_reg[DIV_BITS-1];
    assign out_side  = side_reg[DIV_BITS-1];
    assign out_lane  = lane_reg[DIV_BITS-1];

endmodule

`default_nettype wire
